[design/dsp_pkg.sv]
// Package: pool types, constants and the top-level sequencer states.
`timescale 1ns / 1ps
`default_nettype none
package dsp_pkg;

  localparam int POOL_SIZE = 64;
  localparam int SLOT_W = 6;

  localparam logic CFG_INITIAL_STRENGTH = 1'b0;
  localparam logic CFG_DECAY_RATE = 1'b1;

  localparam logic MODE_CREATE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam logic [1:0] KIND_NONE = 2'd0;

  typedef struct packed {
    logic        mode;
    logic [15:0] dt;
    logic [1:0]  activity;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [7:0]        alpha;
    logic [1:0]        kind;
    logic [15:0]       x_out;
    logic [15:0]       y_out;
    logic              freed;
    logic              pool_full;
    logic              entry_valid;
    logic              last;
  } out_t;

  typedef struct packed {
    logic        active;
    logic [15:0] strength;
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
  } cell_rec_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRD,
    S_CLOAD,
    S_TEVAL,
    S_DIV,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

[design/dsp_cell.sv]
// One pool slot record; rotates to its neighbor or loads a new entry.
`timescale 1ns / 1ps
`default_nettype none
module dsp_cell
  import dsp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cell_ctl_t ctl,
  input  wire cell_rec_t nbr,
  input  wire cell_rec_t ld,
  output cell_rec_t      rec
);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.active <= 1'b0;
    end else if (ctl.shift) begin
      rec <= nbr;
    end else if (ctl.load) begin
      rec <= ld;
    end
  end

endmodule
`default_nettype wire

[design/dsp_div.sv]
// Alpha unit: floor(strength*255/initial), saturated, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dsp_div
  import dsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] strength,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [7:0]       alpha
);

  logic [23:0] num;
  logic [16:0] rem;
  logic [16:0] trial;
  logic [7:0]  nbits;
  logic [3:0]  cnt;
  logic        busy;

  assign num = {strength, 8'd0} - {8'd0, strength};
  assign trial = {rem[15:0], nbits[7]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      if (divisor == 16'd0) begin
        alpha <= 8'd0;
        done <= 1'b1;
        busy <= 1'b0;
      end else if (num >= {divisor, 8'd0}) begin
        alpha <= 8'hFF;
        done <= 1'b1;
        busy <= 1'b0;
      end else begin
        rem <= {1'b0, num[23:8]};
        nbits <= num[7:0];
        cnt <= 4'd8;
        busy <= 1'b1;
        done <= 1'b0;
      end
    end else if (busy) begin
      nbits <= {nbits[6:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= trial - {1'b0, divisor};
        alpha <= {alpha[6:0], 1'b1};
      end else begin
        rem <= trial;
        alpha <= {alpha[6:0], 1'b0};
      end
      cnt <= cnt - 4'd1;
      busy <= (cnt != 4'd1);
      done <= (cnt == 4'd1);
    end else begin
      done <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[design/decaying_slot_pool_core.sv]
// Top level: slot ring, free list, decay step and result register.
// A pool of 64 slots held in a ring of cells, with a FIFO free list in a
// small memory. A create request reads the free list, loads the cell and
// runs the alpha division. A tick request rotates the ring once, one slot per
// cycle while no active slot is worked on; a live slot runs the alpha division
// (one quotient bit per cycle), a freed slot goes straight to its result, and
// each result can be held by out_stall. One request is worked on at a time.
`timescale 1ns / 1ps
`default_nettype none
module decaying_slot_pool_core
  import dsp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  state_t st, st_next;

  logic [15:0] initial_strength;
  logic [15:0] decay_rate;

  in_t               req;
  logic [31:0]       prod;
  logic [SLOT_W-1:0] idx;
  logic              any;
  logic [SLOT_W-1:0] head;
  logic [SLOT_W:0]   count;
  logic [SLOT_W-1:0] qrd;

  logic [SLOT_W-1:0] fq_mem [POOL_SIZE];
  logic [POOL_SIZE-1:0] fq_vld;

  cell_rec_t rec [POOL_SIZE];
  cell_rec_t wb_rec;
  cell_rec_t ld_rec;
  cell_ctl_t ctl [POOL_SIZE];

  out_t res;
  out_t res_init;
  logic div_start;
  logic div_done;
  logic [7:0] div_alpha;
  logic [15:0] div_str;

  logic        in_acc;
  logic        out_acc;
  logic [23:0] whole;
  logic        expire;
  logic [24:0] rnd;
  logic        more;
  logic        shift_en;
  logic        load_en;
  logic        push;
  logic [SLOT_W-1:0] tail;
  logic [1:0]  act_kind;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (st != S_IDLE);
  assign out_valid = (st == S_OUT);
  assign tail = head + count[SLOT_W-1:0];
  assign act_kind = (req.activity == KIND_RESERVED) ? KIND_NONE : req.activity;

  // decay of the record at the ring head
  assign whole = {rec[0].strength, 8'd0};
  assign expire = (prod >= {8'd0, whole});
  assign rnd = {1'b0, whole - prod[23:0]} + 25'd255;

  assign div_str = (st == S_CLOAD) ? initial_strength : wb_rec.strength;

  always_comb begin
    res_init = '0;
    res_init.pool_full = (in_data.mode == MODE_CREATE);
    res_init.last = 1'b1;
  end

  always_comb begin
    more = 1'b0;
    for (int j = 1; j < POOL_SIZE; j++) begin
      if (rec[j].active && ({1'b0, SLOT_W'(j)} + {1'b0, idx} <= (SLOT_W+1)'(POOL_SIZE - 1))) begin
        more = 1'b1;
      end
    end
  end

  always_comb begin
    wb_rec = rec[0];
    if (rec[0].active) begin
      if (expire) begin
        wb_rec.active = 1'b0;
        wb_rec.strength = 16'd0;
      end else begin
        wb_rec.strength = rnd[23:8];
      end
    end
    ld_rec.active = 1'b1;
    ld_rec.strength = initial_strength;
    ld_rec.kind = act_kind;
    ld_rec.x = req.pos_x;
    ld_rec.y = req.pos_y;
  end

  genvar g;
  generate
    for (g = 0; g < POOL_SIZE; g++) begin : g_cell
      assign ctl[g].shift = shift_en;
      assign ctl[g].load = load_en && (qrd == SLOT_W'(g));
      dsp_cell u_cell (
        .clk (clk),
        .rst (rst),
        .ctl (ctl[g]),
        .nbr ((g == POOL_SIZE - 1) ? wb_rec : rec[(g + 1) % POOL_SIZE]),
        .ld  (ld_rec),
        .rec (rec[g])
      );
    end
  endgenerate

  dsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .strength (div_str),
    .divisor  (initial_strength),
    .done     (div_done),
    .alpha    (div_alpha)
  );

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.mode == MODE_TICK) begin
            st_next = S_TEVAL;
          end else if (count == '0) begin
            st_next = S_OUT;
          end else begin
            st_next = S_CRD;
          end
        end
      end
      S_CRD:   st_next = S_CLOAD;
      S_CLOAD: st_next = S_DIV;
      S_TEVAL: begin
        if (rec[0].active) begin
          st_next = expire ? S_OUT : S_DIV;
        end else if (idx == SLOT_W'(POOL_SIZE - 1)) begin
          st_next = any ? S_IDLE : S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          st_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (req.mode == MODE_TICK && idx != SLOT_W'(POOL_SIZE - 1)) begin
            st_next = S_TEVAL;
          end else begin
            st_next = S_IDLE;
          end
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    shift_en = (st == S_TEVAL);
    load_en = (st == S_CLOAD);
    div_start = (st == S_CLOAD) || (st == S_TEVAL && rec[0].active && !expire);
    push = (st == S_TEVAL) && rec[0].active && expire && (count < (SLOT_W+1)'(POOL_SIZE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      initial_strength <= 16'd25600;
      decay_rate <= 16'd256;
      head <= '0;
      count <= (SLOT_W+1)'(POOL_SIZE);
      fq_vld <= '0;
      idx <= '0;
      any <= 1'b0;
    end else begin
      st <= st_next;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INITIAL_STRENGTH: initial_strength <= cfg_data;
          CFG_DECAY_RATE:       decay_rate <= cfg_data;
          default: ;
        endcase
      end

      qrd <= fq_vld[head] ? fq_mem[head] : head;
      if (push) begin
        fq_mem[tail] <= idx;
        fq_vld[tail] <= 1'b1;
        count <= count + 1'b1;
      end

      if (in_acc) begin
        req <= in_data;
        prod <= {16'd0, decay_rate} * {16'd0, in_data.dt};
        idx <= '0;
        any <= 1'b0;
        res <= res_init;
      end

      if (st == S_CLOAD) begin
        head <= head + 1'b1;
        count <= count - 1'b1;
        res.slot <= qrd;
        res.kind <= act_kind;
        res.x_out <= req.pos_x;
        res.y_out <= req.pos_y;
        res.freed <= 1'b0;
        res.pool_full <= 1'b0;
        res.entry_valid <= 1'b1;
        res.last <= 1'b1;
      end

      if (st == S_TEVAL) begin
        if (rec[0].active) begin
          any <= 1'b1;
          res.slot <= idx;
          res.kind <= rec[0].kind;
          res.x_out <= rec[0].x;
          res.y_out <= rec[0].y;
          res.freed <= expire;
          res.pool_full <= 1'b0;
          res.entry_valid <= 1'b1;
          res.last <= !more;
          res.alpha <= 8'd0;
        end else if (idx != SLOT_W'(POOL_SIZE - 1)) begin
          idx <= idx + 1'b1;
        end
      end

      if (st == S_DIV && div_done) begin
        res.alpha <= div_alpha;
      end

      if (out_acc && req.mode == MODE_TICK && idx != SLOT_W'(POOL_SIZE - 1)) begin
        idx <= idx + 1'b1;
      end
    end
  end

  assign out_data = res;

endmodule
`default_nettype wire

[tb/sv/decaying_slot_pool_core_tb.sv]
// Testbench: directed and random create/tick requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module decaying_slot_pool_core_tb;
  import dsp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  decaying_slot_pool_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // pool model
  logic [15:0] pm_init;
  logic [15:0] pm_rate;
  logic [15:0] pm_strength [POOL_SIZE];
  logic        pm_active [POOL_SIZE];
  logic [1:0]  pm_kind [POOL_SIZE];
  logic [15:0] pm_x [POOL_SIZE];
  logic [15:0] pm_y [POOL_SIZE];
  logic [5:0]  pm_free [POOL_SIZE];
  logic [5:0]  pm_head;
  int          pm_count;

  out_t pending_results [$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  bit   rx_stall_en = 1'b1;

  function automatic void queue_expected(out_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic logic [7:0] alpha_of(logic [15:0] s);
    int unsigned a;
    if (pm_init == 0) return 8'd0;
    a = (32'(s) * 255) / 32'(pm_init);
    return (a > 255) ? 8'd255 : a[7:0];
  endfunction

  function automatic out_t slot_result(int i, logic [7:0] a, logic fr);
    out_t r;
    r = '0;
    r.slot = i[5:0];
    r.alpha = a;
    r.kind = pm_kind[i];
    r.x_out = pm_x[i];
    r.y_out = pm_y[i];
    r.freed = fr;
    r.entry_valid = 1'b1;
    return r;
  endfunction

  task automatic predict_request(in_t req);
    out_t r;
    int   n;
    int   s;
    logic [31:0] prod, whole;
    if (req.mode == MODE_CREATE) begin
      r = '0;
      if (pm_count == 0) begin
        r.pool_full = 1'b1;
      end else begin
        s = pm_free[pm_head];
        pm_head = pm_head + 6'd1;
        pm_count--;
        pm_strength[s] = pm_init;
        pm_active[s] = 1'b1;
        pm_kind[s] = (req.activity == KIND_RESERVED) ? KIND_NONE : req.activity;
        pm_x[s] = req.pos_x;
        pm_y[s] = req.pos_y;
        r = slot_result(s, alpha_of(pm_init), 1'b0);
      end
      r.last = 1'b1;
      queue_expected(r);
    end else begin
      n = 0;
      for (int i = 0; i < POOL_SIZE; i++) begin
        if (pm_active[i]) begin
          prod = 32'(pm_rate) * 32'(req.dt);
          whole = 32'(pm_strength[i]) << 8;
          if (n > 0) queue_expected(r);
          if (prod >= whole) begin
            pm_strength[i] = '0;
            pm_active[i] = 1'b0;
            if (pm_count < POOL_SIZE) begin
              pm_free[6'(pm_head + pm_count)] = i[5:0];
              pm_count++;
            end
            r = slot_result(i, 8'd0, 1'b1);
          end else begin
            pm_strength[i] = 16'((whole - prod + 255) >> 8);
            r = slot_result(i, alpha_of(pm_strength[i]), 1'b0);
          end
          n++;
        end
      end
      if (n == 0) r = '0;
      r.last = 1'b1;
      queue_expected(r);
    end
  endtask

  task automatic send_request(in_t req, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    predict_request(req);
    do @(posedge clk); while (in_stall);
  endtask

  function automatic in_t make_req(logic m, logic [15:0] dt, logic [1:0] act,
                                   logic [15:0] x, logic [15:0] y);
    in_t q;
    q.mode = m; q.dt = dt; q.activity = act; q.pos_x = x; q.pos_y = y;
    return q;
  endfunction

  function automatic in_t rand_req(int create_pct);
    return make_req(($urandom_range(0, 99) < create_pct) ? MODE_CREATE : MODE_TICK,
                    16'($urandom), 2'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INITIAL_STRENGTH) pm_init = val; else pm_rate = val;
  endtask

  // checker and receiver stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result slot=%0d", out_data.slot);
          fail_count++;
        end else begin : cmp
          out_t e;
          e = pending_results.pop_front();
          if (out_data.slot !== e.slot) begin
            $error("slot exp %0d got %0d", e.slot, out_data.slot); fail_count++;
          end
          if (out_data.alpha !== e.alpha) begin
            $error("alpha exp %0d got %0d", e.alpha, out_data.alpha); fail_count++;
          end
          if (out_data.kind !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, out_data.kind); fail_count++;
          end
          if (out_data.x_out !== e.x_out) begin
            $error("x_out exp %0h got %0h", e.x_out, out_data.x_out); fail_count++;
          end
          if (out_data.y_out !== e.y_out) begin
            $error("y_out exp %0h got %0h", e.y_out, out_data.y_out); fail_count++;
          end
          if (out_data.freed !== e.freed) begin
            $error("freed exp %0d got %0d", e.freed, out_data.freed); fail_count++;
          end
          if (out_data.pool_full !== e.pool_full) begin
            $error("pool_full exp %0d got %0d", e.pool_full, out_data.pool_full);
            fail_count++;
          end
          if (out_data.entry_valid !== e.entry_valid) begin
            $error("entry_valid exp %0d got %0d", e.entry_valid, out_data.entry_valid);
            fail_count++;
          end
          if (out_data.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_data.last); fail_count++;
          end
        end
      end
    end
  end

  initial begin : rx_stall_gen
    int w;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        w = rx_stall_en ? $urandom_range(0, 5) : 0;
        if (w != 0) begin
          out_stall <= 1'b1;
          repeat (w) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_request(make_req(MODE_TICK, 16'h0100, 2'd0, 16'd0, 16'd0));
    send_request(make_req(MODE_CREATE, 16'd0, 2'd1, 16'hFFFF, 16'h0000));
    send_request(make_req(MODE_CREATE, 16'hFFFF, 2'd2, 16'h0000, 16'hFFFF));
    send_request(make_req(MODE_CREATE, 16'd0, 2'd3, 16'h1234, 16'hABCD));
    send_request(make_req(MODE_TICK, 16'h0000, 2'd0, 16'd0, 16'd0));
    send_request(make_req(MODE_TICK, 16'h0A00, 2'd0, 16'd0, 16'd0));
    send_request(make_req(MODE_TICK, 16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF));
    drain_results();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_INITIAL_STRENGTH, 16'hFFFF);
    write_reg(CFG_DECAY_RATE, 16'd0);
    send_request(make_req(MODE_CREATE, 16'd0, 2'd1, 16'd5, 16'd6));
    send_request(make_req(MODE_TICK, 16'hFFFF, 2'd0, 16'd0, 16'd0));
    drain_results();
    write_reg(CFG_INITIAL_STRENGTH, 16'd1);
    send_request(make_req(MODE_TICK, 16'd1, 2'd0, 16'd0, 16'd0));
    drain_results();
    write_reg(CFG_DECAY_RATE, 16'd1);
    send_request(make_req(MODE_TICK, 16'd1, 2'd0, 16'd0, 16'd0));
    drain_results();
    write_reg(CFG_INITIAL_STRENGTH, 16'd0);
    send_request(make_req(MODE_CREATE, 16'd0, 2'd2, 16'd7, 16'd8));
    send_request(make_req(MODE_TICK, 16'd0, 2'd0, 16'd0, 16'd0));
    drain_results();
    write_reg(CFG_INITIAL_STRENGTH, 16'd25600);
    write_reg(CFG_DECAY_RATE, 16'hFFFF);
    send_request(make_req(MODE_TICK, 16'hFFFF, 2'd0, 16'd0, 16'd0));
    drain_results();
  endtask

  task automatic test_pool_full();
    write_reg(CFG_DECAY_RATE, 16'd1);
    for (int i = 0; i < 66; i++)
      send_request(rand_req(100), (i % 8) == 0);
    send_request(make_req(MODE_TICK, 16'h0010, 2'd0, 16'd0, 16'd0));
    drain_results();
    write_reg(CFG_DECAY_RATE, 16'hFFFF);
    send_request(make_req(MODE_TICK, 16'hFFFF, 2'd0, 16'd0, 16'd0));
    drain_results();
  endtask

  task automatic test_random_traffic();
    int ph;
    for (int i = 0; i < 50; i++) begin
      if (i % 10 == 0) begin
        drain_results();
        ph = i / 10;
        write_reg(CFG_INITIAL_STRENGTH, 16'($urandom_range(1, 65535)));
        write_reg(CFG_DECAY_RATE, (ph == 0) ? 16'd0 : 16'($urandom_range(0, 2048)));
        rx_stall_en = (ph != 2);
      end
      if (i == 25) drain_results();
      send_request(rand_req(70), ph != 3);
    end
    drain_results();
  endtask

  initial begin
    pm_init = 16'd25600;
    pm_rate = 16'd256;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pm_strength[i] = '0; pm_active[i] = 1'b0; pm_kind[i] = '0;
      pm_x[i] = '0; pm_y[i] = '0; pm_free[i] = i[5:0];
    end
    pm_head = '0;
    pm_count = POOL_SIZE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_pool_full();
    test_random_traffic();
    if (fail_count == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
